// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL core of the bit packer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HCBP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("hcbp assertion failed");
`define HCBP_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("hcbp forbidden condition seen");
`else
`define HCBP_ASSERT(lbl, clk, rst, prop)
`define HCBP_NEVER(lbl, clk, rst, expr)
`endif
`endif

// ===== rtl/hcbp_pkg.sv =====
// Types and constants of the Huffman code bit packer.
`default_nettype none
package hcbp_pkg;

  localparam int NumSymbolsDef = 128;
  localparam int MaxCodeLenDef = 31;

  localparam int CodeW  = 31;
  localparam int LenW   = 5;
  localparam int SymW   = 7;
  localparam int AccW   = 7;
  localparam int CntW   = 3;
  localparam int ByteW  = 8;
  localparam int WorkW  = AccW + CodeW;
  localparam int TotalW = 6;

  // Request command codes
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_ENCODE = 1'b1;

  // Table entry: code left-aligned in the word, plus its length
  typedef struct packed {
    logic [CodeW-1:0] code_left;
    logic [LenW-1:0]  len;
  } entry_t;

  // One encode job handed from front to back
  typedef struct packed {
    entry_t entry;
    logic   is_end;
  } job_t;

  // Queue fill status
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Pending bits kept between jobs
  typedef struct packed {
    logic [AccW-1:0] acc;
    logic [CntW-1:0] count;
  } pend_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } back_state_t;

endpackage
`default_nettype wire

// ===== rtl/hcbp_front.sv =====
// Front end: accepts requests, owns the code table, issues encode jobs.
`default_nettype none
module hcbp_front #(
  parameter int NUM_SYMBOLS  = hcbp_pkg::NumSymbolsDef,
  parameter int MAX_CODE_LEN = hcbp_pkg::MaxCodeLenDef
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire                          cmd,
  input  wire  [hcbp_pkg::SymW-1:0]    symbol,
  input  wire  [hcbp_pkg::CodeW-1:0]   code_value,
  input  wire  [hcbp_pkg::LenW-1:0]    code_length,
  output logic                         push_valid,
  output hcbp_pkg::job_t               push_job,
  input  wire  hcbp_pkg::q_status_t    q_status
);

  localparam int IdxW = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;

  hcbp_pkg::entry_t            mem [NUM_SYMBOLS];
  logic [NUM_SYMBOLS-1:0]      loaded;
  hcbp_pkg::entry_t            rd_entry;
  logic                        rd_hit;
  logic                        rd_end;
  logic                        s1_valid;

  logic                        in_fire;
  logic                        in_range;
  logic [IdxW-1:0]             idx;
  logic [hcbp_pkg::LenW-1:0]   len_sat;
  logic [hcbp_pkg::LenW-1:0]   left_shift;
  hcbp_pkg::entry_t            wr_entry;

  // Accept while the read stage is empty or drains this cycle
  assign in_ready = !s1_valid || !q_status.full;
  assign in_fire  = in_valid && in_ready;
  assign in_range = int'(symbol) < NUM_SYMBOLS;
  assign idx      = IdxW'(symbol);

  // Saturate length, left-align code; bits above the length shift out
  always_comb begin
    if (int'(code_length) > MAX_CODE_LEN) begin
      len_sat = hcbp_pkg::LenW'(MAX_CODE_LEN);
    end else begin
      len_sat = code_length;
    end
    left_shift         = hcbp_pkg::LenW'(hcbp_pkg::CodeW) - len_sat;
    wr_entry.code_left = code_value << left_shift;
    wr_entry.len       = len_sat;
  end

  // Write the table on loads
  always_ff @(posedge clk) begin
    if (in_fire && cmd == hcbp_pkg::CMD_LOAD && in_range) begin
      mem[idx] <= wr_entry;
    end
  end

  // Track which entries hold a code
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= '0;
    end else if (in_fire && cmd == hcbp_pkg::CMD_LOAD && in_range) begin
      loaded[idx] <= 1'b1;
    end
  end

  // Read the table for encodes
  always_ff @(posedge clk) begin
    if (in_fire && cmd == hcbp_pkg::CMD_ENCODE) begin
      rd_entry <= mem[idx];
      rd_hit   <= loaded[idx] && in_range;
      rd_end   <= (symbol == '0);
    end
  end

  // Hold the read stage until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire && cmd == hcbp_pkg::CMD_ENCODE) begin
      s1_valid <= 1'b1;
    end else if (!q_status.full) begin
      s1_valid <= 1'b0;
    end
  end

  // Unloaded or out-of-range entries carry no bits
  assign push_valid      = s1_valid;
  assign push_job.entry  = rd_hit ? rd_entry : '0;
  assign push_job.is_end = rd_end;

endmodule
`default_nettype wire

// ===== rtl/hcbp_queue.sv =====
// Two-entry job queue between front and back.
`default_nettype none
module hcbp_queue (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         push,
  input  wire  hcbp_pkg::job_t        push_job,
  input  wire                         pop,
  output hcbp_pkg::job_t              head,
  output hcbp_pkg::q_status_t         status
);

  hcbp_pkg::job_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           do_push;
  logic           do_pop;

  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = slots[rd_ptr];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/hcbp_back.sv =====
// Back end: packs code bits MSB first and emits bytes through an output register.
`default_nettype none
module hcbp_back (
  input  wire                           clk,
  input  wire                           rst,
  input  wire  hcbp_pkg::job_t          head,
  input  wire  hcbp_pkg::q_status_t     q_status,
  output logic                          pop,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic [hcbp_pkg::ByteW-1:0]    out_byte,
  output logic                          final_of_stream,
  output logic                          last,
  output hcbp_pkg::pend_t               pend
);

  hcbp_pkg::back_state_t            state, state_next;
  logic [hcbp_pkg::WorkW-1:0]       wbuf, wbuf_next;
  logic [hcbp_pkg::TotalW-1:0]      total, total_next;
  logic                             is_end, is_end_next;
  hcbp_pkg::pend_t                  pend_next;
  logic                             out_valid_next;
  logic [hcbp_pkg::ByteW-1:0]       out_byte_next;
  logic                             final_next;
  logic                             last_next;

  // State, pending bits and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hcbp_pkg::ST_IDLE;
      pend      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pend      <= pend_next;
      out_valid <= out_valid_next;
    end
  end

  // Working data and output payload
  always_ff @(posedge clk) begin
    wbuf            <= wbuf_next;
    total           <= total_next;
    is_end          <= is_end_next;
    out_byte        <= out_byte_next;
    final_of_stream <= final_next;
    last            <= last_next;
  end

  // Load a job, emit one byte per cycle while the output is free, then store leftover bits
  always_comb begin
    logic                        out_free;
    logic                        emit_full;
    logic                        emit_pad;
    logic [hcbp_pkg::TotalW-1:0] rem;

    out_free  = !out_valid || out_ready;
    emit_full = total >= hcbp_pkg::TotalW'(hcbp_pkg::ByteW);
    emit_pad  = is_end && (total != '0) && !emit_full;
    rem       = total - hcbp_pkg::TotalW'(hcbp_pkg::ByteW);

    state_next     = state;
    wbuf_next      = wbuf;
    total_next     = total;
    is_end_next    = is_end;
    pend_next      = pend;
    pop            = 1'b0;
    out_valid_next = out_valid && !out_ready;
    out_byte_next  = out_byte;
    final_next     = final_of_stream;
    last_next      = last;

    unique case (state)
      hcbp_pkg::ST_IDLE: begin
        if (!q_status.empty) begin
          pop         = 1'b1;
          wbuf_next   = {pend.acc, {hcbp_pkg::CodeW{1'b0}}}
                      | ({head.entry.code_left, {hcbp_pkg::AccW{1'b0}}} >> pend.count);
          total_next  = hcbp_pkg::TotalW'(pend.count)
                      + hcbp_pkg::TotalW'(head.entry.len);
          is_end_next = head.is_end;
          state_next  = hcbp_pkg::ST_RUN;
        end
      end
      hcbp_pkg::ST_RUN: begin
        if (emit_full || emit_pad) begin
          if (out_free) begin
            out_valid_next = 1'b1;
            out_byte_next  = wbuf[hcbp_pkg::WorkW-1 -: hcbp_pkg::ByteW];
            wbuf_next      = wbuf << hcbp_pkg::ByteW;
            if (emit_full) begin
              total_next = rem;
              final_next = is_end && (rem == '0);
              last_next  = (rem < hcbp_pkg::TotalW'(hcbp_pkg::ByteW))
                         && !(is_end && rem != '0);
            end else begin
              total_next = '0;
              final_next = 1'b1;
              last_next  = 1'b1;
            end
          end
        end else begin
          // Keep leftover bits; the end marker clears them
          if (is_end) begin
            pend_next = '0;
          end else begin
            pend_next.acc   = wbuf[hcbp_pkg::WorkW-1 -: hcbp_pkg::AccW];
            pend_next.count = total[hcbp_pkg::CntW-1:0];
          end
          state_next = hcbp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = hcbp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/huffman_code_bit_packer_core.sv =====
// Huffman code bit packer: 128-entry code table, MSB-first packing, byte output.
// Load requests write the table on acceptance; an encode request passes the read stage
// and the job queue to the back end, which then emits B bytes, B = 0..5.
// Throughput is set by the packing engine, which handles one encode at a time.
// Reset (rst, synchronous) marks all table entries unloaded and clears pending bits.
`default_nettype none
`include "assert_macros.svh"
module huffman_code_bit_packer_core #(
  parameter int NUM_SYMBOLS  = hcbp_pkg::NumSymbolsDef,
  parameter int MAX_CODE_LEN = hcbp_pkg::MaxCodeLenDef
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire                          cmd,
  input  wire  [hcbp_pkg::SymW-1:0]    symbol,
  input  wire  [hcbp_pkg::CodeW-1:0]   code_value,
  input  wire  [hcbp_pkg::LenW-1:0]    code_length,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [hcbp_pkg::ByteW-1:0]   out_byte,
  output logic                         final_of_stream,
  output logic                         last
);

  logic                  push_valid;
  hcbp_pkg::job_t        push_job;
  hcbp_pkg::job_t        head;
  hcbp_pkg::q_status_t   q_status;
  logic                  pop;
  hcbp_pkg::pend_t       pend;

  hcbp_front #(
    .NUM_SYMBOLS  (NUM_SYMBOLS),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .symbol      (symbol),
    .code_value  (code_value),
    .code_length (code_length),
    .push_valid  (push_valid),
    .push_job    (push_job),
    .q_status    (q_status)
  );

  hcbp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push_valid),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  hcbp_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .q_status        (q_status),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .final_of_stream (final_of_stream),
    .last            (last),
    .pend            (pend)
  );

  // A stream-final byte always closes its request
  `HCBP_ASSERT(a_final_is_last, clk, rst, (out_valid && final_of_stream) |-> last)
  // Queue status never reads full and empty together
  `HCBP_NEVER(a_queue_status, clk, rst, q_status.full && q_status.empty)
  // Pending bits below the valid count stay zero
  `HCBP_ASSERT(a_pend_clean, clk, rst, ((pend.acc << pend.count) == '0))
  // A pop only happens on a non-empty queue
  `HCBP_NEVER(a_pop_empty, clk, rst, pop && q_status.empty)

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the Huffman code bit packer core.
module testbench;

  localparam int TABLE_DEPTH  = 128;
  localparam int LEN_LIMIT    = 31;
  localparam logic [hcbp_pkg::SymW-1:0] END_MARKER = '0;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 100000;

  // One expected output byte with its flags
  typedef struct packed {
    logic [hcbp_pkg::ByteW-1:0] data;
    logic                       fin;
    logic                       lst;
  } byte_exp_t;

  // One directed request; typed rows carry their bytes, earliest in the top byte
  typedef struct packed {
    logic                       c;
    logic [hcbp_pkg::SymW-1:0]  s;
    logic [hcbp_pkg::CodeW-1:0] v;
    logic [hcbp_pkg::LenW-1:0]  l;
    logic                       typed;
    logic [2:0]                 n;
    logic [39:0]                b;
  } stim_row_t;

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  logic                       cmd;
  logic [hcbp_pkg::SymW-1:0]  symbol;
  logic [hcbp_pkg::CodeW-1:0] code_value;
  logic [hcbp_pkg::LenW-1:0]  code_length;
  logic                       out_valid;
  logic                       out_ready;
  logic [hcbp_pkg::ByteW-1:0] out_byte;
  logic                       final_of_stream;
  logic                       last;

  // Predictor state: code table and pending bits
  logic [hcbp_pkg::CodeW-1:0] code_bits [0:TABLE_DEPTH-1];
  logic [hcbp_pkg::LenW-1:0]  code_len  [0:TABLE_DEPTH-1];
  logic [hcbp_pkg::AccW-1:0]  pend_acc;
  logic [hcbp_pkg::CntW-1:0]  pend_cnt;

  byte_exp_t burst [0:4];
  int        burst_n;
  byte_exp_t expected_bytes [$];
  stim_row_t stim_rows [$];

  int errors;
  int cycles;
  int snd_idle;
  int rcv_idle;
  bit hold_req;

  huffman_code_bit_packer_core uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .cmd             (cmd),
    .symbol          (symbol),
    .code_value      (code_value),
    .code_length     (code_length),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .final_of_stream (final_of_stream),
    .last            (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one request to the predictor; fill burst with the bytes it emits
  task automatic apply_request(input logic c, input logic [hcbp_pkg::SymW-1:0] s,
                               input logic [hcbp_pkg::CodeW-1:0] v,
                               input logic [hcbp_pkg::LenW-1:0] l);
    logic [63:0] work;
    logic [63:0] shifted;
    int          total;
    int          clen;
    begin
      burst_n = 0;
      if (c == hcbp_pkg::CMD_LOAD) begin
        clen = (int'(l) > LEN_LIMIT) ? LEN_LIMIT : int'(l);
        code_len[s] = hcbp_pkg::LenW'(clen);
        work = {33'd0, v} & ((64'd1 << clen) - 64'd1);
        code_bits[s] = work[hcbp_pkg::CodeW-1:0];
      end else begin
        clen = int'(code_len[s]);
        work = ({57'd0, pend_acc} << clen) | {33'd0, code_bits[s]};
        total = int'(pend_cnt) + clen;
        // Emit every full byte, earliest bit in the MSB
        while (total >= 8) begin
          total -= 8;
          shifted = work >> total;
          burst[burst_n] = '{data: shifted[7:0], fin: 1'b0, lst: 1'b0};
          burst_n++;
        end
        work = work & ((64'd1 << total) - 64'd1);
        // Pad and flush on the end marker
        if (s == END_MARKER) begin
          if (total > 0) begin
            shifted = work << (8 - total);
            burst[burst_n] = '{data: shifted[7:0], fin: 1'b0, lst: 1'b0};
            burst_n++;
          end
          work = '0;
          total = 0;
          if (burst_n > 0) burst[burst_n-1].fin = 1'b1;
        end
        pend_acc = work[hcbp_pkg::AccW-1:0];
        pend_cnt = total[hcbp_pkg::CntW-1:0];
        if (burst_n > 0) burst[burst_n-1].lst = 1'b1;
      end
    end
  endtask

  task automatic add_row(input logic c, input logic [hcbp_pkg::SymW-1:0] s,
                         input logic [hcbp_pkg::CodeW-1:0] v,
                         input logic [hcbp_pkg::LenW-1:0] l, input logic typed, input int n,
                         input logic [39:0] b);
    stim_row_t r;
    begin
      r = '{c: c, s: s, v: v, l: l, typed: typed, n: n[2:0], b: b};
      stim_rows.push_back(r);
    end
  endtask

  // Offer one request, wait for acceptance, then queue what it should produce
  task automatic send_request(input logic c, input logic [hcbp_pkg::SymW-1:0] s,
                              input logic [hcbp_pkg::CodeW-1:0] v,
                              input logic [hcbp_pkg::LenW-1:0] l,
                              input logic typed, input int n, input logic [39:0] b);
    byte_exp_t e;
    int        k;
    begin
      while ($urandom_range(0, 99) < snd_idle) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid    <= 1'b1;
      cmd         <= c;
      symbol      <= s;
      code_value  <= v;
      code_length <= l;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      apply_request(c, s, v, l);
      if (typed) begin
        for (k = 0; k < n; k++) begin
          e.data = b[39 - 8*k -: 8];
          e.fin  = (k == n - 1) && (c == hcbp_pkg::CMD_ENCODE) && (s == END_MARKER);
          e.lst  = (k == n - 1);
          expected_bytes.push_back(e);
        end
      end else begin
        for (k = 0; k < burst_n; k++) expected_bytes.push_back(burst[k]);
      end
    end
  endtask

  // Mostly encodes of a small symbol set mixed with loads and end markers
  task automatic random_requests(input int count);
    int                         i;
    int                         pick;
    int                         lsel;
    logic [hcbp_pkg::SymW-1:0]  s;
    logic [hcbp_pkg::CodeW-1:0] v;
    logic [hcbp_pkg::LenW-1:0]  l;
    begin
      for (i = 0; i < count; i++) begin
        pick = $urandom_range(0, 99);
        s = ($urandom_range(0, 3) == 0) ? hcbp_pkg::SymW'($urandom_range(0, 127))
                                        : hcbp_pkg::SymW'($urandom_range(1, 15));
        if (pick < 22) begin
          lsel = $urandom_range(0, 9);
          if (lsel == 0) l = '0;
          else if (lsel == 1) l = hcbp_pkg::LenW'($urandom_range(16, 31));
          else l = hcbp_pkg::LenW'($urandom_range(1, 10));
          v = hcbp_pkg::CodeW'($urandom);
          if ($urandom_range(0, 7) == 0) s = END_MARKER;
          send_request(hcbp_pkg::CMD_LOAD, s, v, l, 1'b0, 0, 40'd0);
        end else if (pick < 32) begin
          send_request(hcbp_pkg::CMD_ENCODE, END_MARKER, hcbp_pkg::CodeW'($urandom),
                       hcbp_pkg::LenW'($urandom), 1'b0, 0, 40'd0);
        end else begin
          send_request(hcbp_pkg::CMD_ENCODE, s, hcbp_pkg::CodeW'($urandom),
                       hcbp_pkg::LenW'($urandom), 1'b0, 0, 40'd0);
        end
      end
    end
  endtask

  // Receive side: random back-pressure, long hold on request, field checks
  initial begin
    byte_exp_t e;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected output byte %h", out_byte);
          errors++;
        end else begin
          e = expected_bytes.pop_front();
          if (out_byte !== e.data) begin
            $error("out_byte: expected %h, got %h", e.data, out_byte);
            errors++;
          end
          if (final_of_stream !== e.fin) begin
            $error("final_of_stream: expected %b, got %b", e.fin, final_of_stream);
            errors++;
          end
          if (last !== e.lst) begin
            $error("last: expected %b, got %b", e.lst, last);
            errors++;
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rcv_idle);
      end
    end
  end

  // Watchdog
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int        i;
    stim_row_t r;
    errors   = 0;
    hold_req = 1'b0;
    snd_idle = 19;
    rcv_idle = 58;
    for (i = 0; i < TABLE_DEPTH; i++) begin
      code_bits[i] = '0;
      code_len[i]  = '0;
    end
    pend_acc = '0;
    pend_cnt = '0;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    cmd         <= hcbp_pkg::CMD_LOAD;
    symbol      <= '0;
    code_value  <= '0;
    code_length <= '0;

    // Directed rows: unloaded entries, all-ones and all-zeros codes, markers
    add_row(hcbp_pkg::CMD_ENCODE, 7'd5,       31'd0,        5'd0,  1'b1, 0, 40'h0);
    add_row(hcbp_pkg::CMD_ENCODE, END_MARKER, 31'd0,        5'd0,  1'b1, 0, 40'h0);
    add_row(hcbp_pkg::CMD_LOAD,   END_MARKER, 31'd0,        5'd0,  1'b1, 0, 40'h0);
    add_row(hcbp_pkg::CMD_LOAD,   7'd127,     31'h7FFFFFFF, 5'd31, 1'b1, 0, 40'h0);
    add_row(hcbp_pkg::CMD_ENCODE, 7'd127,     31'd0,        5'd0,  1'b1, 3, 40'hFFFFFF0000);
    add_row(hcbp_pkg::CMD_ENCODE, END_MARKER, 31'd0,        5'd0,  1'b1, 1, 40'hFE00000000);
    add_row(hcbp_pkg::CMD_LOAD,   7'd1,       31'h7FFFFFFF, 5'd1,  1'b1, 0, 40'h0);
    add_row(hcbp_pkg::CMD_LOAD,   7'd2,       31'd0,        5'd31, 1'b1, 0, 40'h0);
    add_row(hcbp_pkg::CMD_ENCODE, 7'd1,       31'd0,        5'd0,  1'b1, 0, 40'h0);
    add_row(hcbp_pkg::CMD_ENCODE, 7'd127,     31'd0,        5'd0,  1'b1, 4, 40'hFFFFFFFF00);
    add_row(hcbp_pkg::CMD_ENCODE, 7'd2,       31'd0,        5'd0,  1'b1, 3, 40'h0);
    add_row(hcbp_pkg::CMD_ENCODE, 7'd127,     31'd0,        5'd0,  1'b0, 0, 40'h0);
    add_row(hcbp_pkg::CMD_LOAD,   END_MARKER, 31'h7FFFFFFF, 5'd31, 1'b1, 0, 40'h0);
    add_row(hcbp_pkg::CMD_ENCODE, END_MARKER, 31'd0,        5'd0,  1'b1, 5, 40'hFFFFFFFFF8);
    add_row(hcbp_pkg::CMD_LOAD,   7'd3,       31'h7FFFFFFD, 5'd3,  1'b1, 0, 40'h0);
    add_row(hcbp_pkg::CMD_ENCODE, 7'd3,       31'd0,        5'd0,  1'b0, 0, 40'h0);
    add_row(hcbp_pkg::CMD_ENCODE, 7'd3,       31'd0,        5'd0,  1'b0, 0, 40'h0);
    add_row(hcbp_pkg::CMD_ENCODE, 7'd3,       31'd0,        5'd0,  1'b0, 0, 40'h0);
    add_row(hcbp_pkg::CMD_LOAD,   END_MARKER, 31'd0,        5'd0,  1'b1, 0, 40'h0);
    add_row(hcbp_pkg::CMD_ENCODE, END_MARKER, 31'd0,        5'd0,  1'b0, 0, 40'h0);
    add_row(hcbp_pkg::CMD_ENCODE, END_MARKER, 31'd0,        5'd0,  1'b1, 0, 40'h0);
    add_row(hcbp_pkg::CMD_LOAD,   7'd64,      31'h2AAAAAAA, 5'd30, 1'b1, 0, 40'h0);
    add_row(hcbp_pkg::CMD_ENCODE, 7'd64,      31'd0,        5'd0,  1'b0, 0, 40'h0);
    add_row(hcbp_pkg::CMD_LOAD,   7'd127,     31'd0,        5'd0,  1'b1, 0, 40'h0);
    add_row(hcbp_pkg::CMD_ENCODE, 7'd127,     31'd0,        5'd0,  1'b1, 0, 40'h0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    for (i = 0; i < stim_rows.size(); i++) begin
      r = stim_rows[i];
      send_request(r.c, r.s, r.v, r.l, r.typed, r.n, r.b);
    end

    // Random traffic under three idle mixes; hold the output off in the last one
    random_requests(70);
    snd_idle = 58;
    rcv_idle = 19;
    random_requests(70);
    snd_idle = 0;
    rcv_idle = 0;
    hold_req = 1'b1;
    random_requests(60);
    in_valid <= 1'b0;

    // Drain, then allow for late extra bytes
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_bytes.size() != 0) begin
      $error("%0d expected bytes never arrived", expected_bytes.size());
      errors++;
    end
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
